@@ design/erfp_pkg.sv @@
// Shared types, constants and the CRC8 step function for the ESP3 frame parser.
`timescale 1ns / 1ps

package erfp_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'h55;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam int         MIN_RECORD  = 6;
    // Count field of a queued frame; covers the largest store the block supports.
    localparam int         CNT_W       = 6;
    localparam int         QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_USER    = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_NO_SYNC    = 3'd1,
        ERR_HDR_CRC    = 3'd2,
        ERR_DATA_CRC   = 3'd3,
        ERR_WRONG_TYPE = 3'd4,
        ERR_BAD_LENGTH = 3'd5
    } err_t;

    // One job handed from the parser to the result sequencer.
    typedef struct packed {
        logic             is_frame;
        err_t             err;
        logic             bank;
        logic [7:0]       org;
        logic [31:0]      id;
        logic [7:0]       status;
        logic [7:0]       dbm;
        logic [CNT_W-1:0] cnt;
    } job_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } store_wr_t;

    typedef struct packed {
        logic en;
        logic bank;
    } bank_rel_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

@@ design/erfp_ifs.sv @@
// Valid/ready channel interfaces for received bytes and parser results.
`timescale 1ns / 1ps

interface erfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface erfp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  user_byte;
    logic [7:0]  radio_org;
    logic [31:0] sender_id;
    logic [7:0]  telegram_status;
    logic [7:0]  signal_dbm;
    logic [4:0]  user_count;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output user_byte, output radio_org,
                    output sender_id, output telegram_status, output signal_dbm,
                    output user_count, output error_code, output last, input ready);
    modport sink (input valid, input kind, input user_byte, input radio_org,
                  input sender_id, input telegram_status, input signal_dbm,
                  input user_count, input error_code, input last, output ready);
endinterface

@@ design/erfp_front.sv @@
// Byte parser: frame state machine, CRC8, header checks and job generation.
`timescale 1ns / 1ps

module erfp_front #(
    parameter int MAX_USER_BYTES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    erfp_rx_if.sink             rx,
    input  logic [7:0]          accepted_type,
    input  logic                q_full,
    output logic                push,
    output erfp_pkg::job_t      push_job,
    output erfp_pkg::store_wr_t store_wr,
    input  erfp_pkg::bank_rel_t bank_rel
);
    import erfp_pkg::*;

    localparam int BCW = $clog2(MAX_USER_BYTES + MIN_RECORD + 256);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_HCRC,
        PH_BODY,
        PH_DCRC
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [BCW-1:0] cnt_reg, cnt_next;
    logic [15:0]    rec_reg, rec_next;
    logic [7:0]     opt_reg, opt_next;
    logic [7:0]     typ_reg, typ_next;
    logic [7:0]     crc_reg, crc_next;
    logic [7:0]     org_reg, org_next;
    logic [31:0]    id_reg, id_next;
    logic [7:0]     st_reg, st_next;
    logic [7:0]     dbm_reg, dbm_next;
    logic           garb_reg, garb_next;
    logic           bank_reg, bank_next;
    logic [1:0]     busy_reg, busy_next;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  crc_new;
    logic [16:0] p17;
    logic [16:0] n17;

    assign rx.ready = !q_full && !(phase_reg == PH_BODY && busy_reg[bank_reg]);
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;
    assign crc_new  = crc8_step(crc_reg, b);
    assign p17      = 17'(cnt_reg);
    assign n17      = 17'(rec_reg) - 17'(MIN_RECORD);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rec_next   = rec_reg;
        opt_next   = opt_reg;
        typ_next   = typ_reg;
        crc_next   = crc_reg;
        org_next   = org_reg;
        id_next    = id_reg;
        st_next    = st_reg;
        dbm_next   = dbm_reg;
        garb_next  = garb_reg;
        bank_next  = bank_reg;
        push       = 1'b0;
        push_job   = '0;
        store_wr   = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (b == SYNC_BYTE)
                    begin
                        garb_next  = 1'b0;
                        phase_next = PH_HEADER;
                        cnt_next   = '0;
                        crc_next   = '0;
                        rec_next   = '0;
                        opt_next   = '0;
                        typ_next   = '0;
                        org_next   = '0;
                        id_next    = '0;
                        st_next    = '0;
                        dbm_next   = '0;
                    end
                    else if (!garb_reg)
                    begin
                        push         = 1'b1;
                        push_job.err = ERR_NO_SYNC;
                        garb_next    = 1'b1;
                    end
                end
                PH_HEADER:
                begin
                    crc_next = crc_new;
                    unique case (cnt_reg[1:0])
                        2'd0: rec_next = {b, 8'h00};
                        2'd1: rec_next = {rec_reg[15:8], b};
                        2'd2: opt_next = b;
                        2'd3: typ_next = b;
                    endcase
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        phase_next = PH_HCRC;
                    end
                end
                PH_HCRC:
                begin
                    // Check order: header CRC, packet type, length.
                    if (b != crc_reg)
                    begin
                        push         = 1'b1;
                        push_job.err = ERR_HDR_CRC;
                    end
                    else if (typ_reg != accepted_type)
                    begin
                        push         = 1'b1;
                        push_job.err = ERR_WRONG_TYPE;
                    end
                    else if (rec_reg < 16'(MIN_RECORD) ||
                             17'(rec_reg) > 17'(MAX_USER_BYTES + MIN_RECORD))
                    begin
                        push         = 1'b1;
                        push_job.err = ERR_BAD_LENGTH;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        cnt_next   = '0;
                        crc_next   = '0;
                    end
                    if (push)
                    begin
                        phase_next = PH_HUNT;
                        garb_next  = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    crc_next = crc_new;
                    if (p17 == 17'd0)
                    begin
                        org_next = b;
                    end
                    else if (p17 <= n17)
                    begin
                        store_wr.en   = 1'b1;
                        store_wr.bank = bank_reg;
                        store_wr.addr = CNT_W'(p17 - 17'd1);
                        store_wr.data = b;
                    end
                    else if (p17 <= n17 + 17'd4)
                    begin
                        id_next = {id_reg[23:0], b};
                    end
                    else if (p17 == n17 + 17'd5)
                    begin
                        st_next = b;
                    end
                    else if (p17 == 17'(rec_reg) + 17'd5)
                    begin
                        dbm_next = b;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (p17 + 17'd1 >= 17'(rec_reg) + 17'(opt_reg))
                    begin
                        phase_next = PH_DCRC;
                    end
                end
                PH_DCRC:
                begin
                    push       = 1'b1;
                    phase_next = PH_HUNT;
                    if (b != crc_reg)
                    begin
                        push_job.err = ERR_DATA_CRC;
                        garb_next    = 1'b1;
                    end
                    else
                    begin
                        push_job.is_frame = 1'b1;
                        push_job.err      = ERR_NONE;
                        push_job.bank     = bank_reg;
                        push_job.org      = org_reg;
                        push_job.id       = id_reg;
                        push_job.status   = st_reg;
                        push_job.dbm      = (opt_reg >= 8'(MIN_RECORD)) ? dbm_reg : 8'h00;
                        push_job.cnt      = CNT_W'(n17);
                        bank_next         = ~bank_reg;
                        garb_next         = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Store bank ownership: a queued frame holds its bank until its summary issues.
    always_comb
    begin
        busy_next = busy_reg;
        if (bank_rel.en)
        begin
            busy_next[bank_rel.bank] = 1'b0;
        end
        if (push && push_job.is_frame)
        begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= '0;
            rec_reg   <= '0;
            opt_reg   <= '0;
            typ_reg   <= '0;
            crc_reg   <= '0;
            org_reg   <= '0;
            id_reg    <= '0;
            st_reg    <= '0;
            dbm_reg   <= '0;
            garb_reg  <= 1'b0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            rec_reg   <= rec_next;
            opt_reg   <= opt_next;
            typ_reg   <= typ_next;
            crc_reg   <= crc_next;
            org_reg   <= org_next;
            id_reg    <= id_next;
            st_reg    <= st_next;
            dbm_reg   <= dbm_next;
            garb_reg  <= garb_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

`ifndef SYNTHESIS
    a_store_wr_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.en |-> !busy_reg[store_wr.bank])
        else $error("user byte written into a bank still owned by a queued frame");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("job pushed into a full queue");

    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bank_rel.en |-> busy_reg[bank_rel.bank])
        else $error("release of a bank that is not owned");
`endif

endmodule

@@ design/erfp_queue.sv @@
// Two-entry job queue between the byte parser and the result sequencer.
`timescale 1ns / 1ps

module erfp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  erfp_pkg::job_t push_job,
    input  logic           pop,
    output logic           head_valid,
    output erfp_pkg::job_t head,
    output logic           full
);
    import erfp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == CW'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ design/erfp_back.sv @@
// Result sequencer: user byte store, read stage and registered result output.
`timescale 1ns / 1ps

module erfp_back #(
    parameter int MAX_USER_BYTES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  erfp_pkg::job_t      head,
    output logic                pop,
    input  erfp_pkg::store_wr_t store_wr,
    output erfp_pkg::bank_rel_t bank_rel,
    erfp_res_if.source          res
);
    import erfp_pkg::*;

    // Byte index runs up to the full user count before the summary issues.
    localparam int IW = $clog2(MAX_USER_BYTES + 1);
    localparam int AW = $clog2(2 * MAX_USER_BYTES);
    localparam int SD = 2 * MAX_USER_BYTES;

    // Two banks: one filled by the parser while the other is read out.
    logic [7:0]    store_mem [SD];
    logic [7:0]    rd_data_reg;

    logic [IW-1:0] idx_reg, idx_next;
    logic          b_valid_reg;
    logic          b_user_reg;
    job_t          b_job_reg;

    logic          out_valid_reg;
    kind_t         kind_reg;
    logic [7:0]    user_byte_reg;
    logic [7:0]    org_reg;
    logic [31:0]   id_reg;
    logic [7:0]    st_reg;
    logic [7:0]    dbm_reg;
    logic [4:0]    cnt_reg;
    err_t          err_reg;
    logic          last_reg;

    logic          advance_out;
    logic          b_move;
    logic          b_free;
    logic          issue;
    logic          is_user;
    logic          rd_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign advance_out = !out_valid_reg || res.ready;
    assign b_move      = b_valid_reg && advance_out;
    assign b_free      = !b_valid_reg || advance_out;
    assign issue       = head_valid && b_free;
    assign is_user     = head.is_frame && (CNT_W'(idx_reg) < head.cnt);
    assign rd_en       = issue && is_user;
    assign pop         = issue && !is_user;
    assign idx_next    = is_user ? idx_reg + 1'b1 : '0;

    assign bank_rel.en   = pop && head.is_frame;
    assign bank_rel.bank = head.bank;

    assign wr_addr = store_wr.bank ? AW'(MAX_USER_BYTES) + AW'(IW'(store_wr.addr))
                                   : AW'(IW'(store_wr.addr));
    assign rd_addr = head.bank ? AW'(MAX_USER_BYTES) + AW'(idx_reg) : AW'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[wr_addr] <= store_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                idx_reg     <= idx_next;
                b_valid_reg <= 1'b1;
            end
            else if (b_move)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_user_reg <= is_user;
            b_job_reg  <= head;
        end
        if (b_move)
        begin
            user_byte_reg <= '0;
            org_reg       <= '0;
            id_reg        <= '0;
            st_reg        <= '0;
            dbm_reg       <= '0;
            cnt_reg       <= '0;
            err_reg       <= ERR_NONE;
            if (b_user_reg)
            begin
                kind_reg      <= KIND_USER;
                user_byte_reg <= rd_data_reg;
                last_reg      <= 1'b0;
            end
            else if (b_job_reg.is_frame)
            begin
                kind_reg <= KIND_SUMMARY;
                org_reg  <= b_job_reg.org;
                id_reg   <= b_job_reg.id;
                st_reg   <= b_job_reg.status;
                dbm_reg  <= b_job_reg.dbm;
                cnt_reg  <= 5'(b_job_reg.cnt);
                last_reg <= 1'b1;
            end
            else
            begin
                kind_reg <= KIND_ERROR;
                err_reg  <= b_job_reg.err;
                last_reg <= 1'b1;
            end
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.kind            = kind_reg;
    assign res.user_byte       = user_byte_reg;
    assign res.radio_org       = org_reg;
    assign res.sender_id       = id_reg;
    assign res.telegram_status = st_reg;
    assign res.signal_dbm      = dbm_reg;
    assign res.user_count      = cnt_reg;
    assign res.error_code      = err_reg;
    assign res.last            = last_reg;

`ifndef SYNTHESIS
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !advance_out) |=> (b_valid_reg && $stable(b_job_reg)))
        else $error("read stage changed while the output was stalled");

    a_frame_all_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.is_frame) |-> (CNT_W'(idx_reg) == head.cnt))
        else $error("frame summary issued before all user bytes");

    a_error_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !head.is_frame) |-> (idx_reg == '0))
        else $error("byte index left nonzero when an error job reached the head");
`endif

endmodule

@@ design/esp3_radio_frame_parser_unit.sv @@
// A frame end or error pushes a job through the queue, read stage and output register.
// Throughput: one received byte per cycle unless stalled; one result per cycle on res.ready.
// Body bytes stall only while both user store banks are held by queued frames.
// The 2-entry job queue stalls the byte input when full.
// Reset: asynchronous, active low; parser hunts for sync, queue and output empty,
// accepted_packet_type returns to 1. No clearing pass is needed.
`timescale 1ns / 1ps

module esp3_radio_frame_parser_unit #(
    parameter int MAX_USER_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    erfp_rx_if.sink     rx,
    erfp_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import erfp_pkg::*;

    // Register map: byte address 0 holds accepted_packet_type.
    localparam logic REG_ACCEPTED_TYPE = 1'b0;

    logic [7:0] accepted_type_reg;
    logic       cfg_write;

    logic       q_push;
    job_t       q_push_job;
    logic       q_pop;
    logic       q_head_valid;
    job_t       q_head;
    logic       q_full;
    store_wr_t  store_wr;
    bank_rel_t  bank_rel;

    // APB: zero wait states; the write lands on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_type_reg <= 8'd1;
        end
        else if (cfg_write && paddr[2] == REG_ACCEPTED_TYPE)
        begin
            accepted_type_reg <= pwdata[7:0];
        end
    end

    // Reads return the register at addresses 0 to 3; addresses 4 to 7 read as zero.
    assign prdata = (paddr[2] == REG_ACCEPTED_TYPE) ? {24'h000000, accepted_type_reg} : '0;

    // Front: take one byte a cycle unless stalled, track the frame, push a job per result run.
    erfp_front #(
        .MAX_USER_BYTES(MAX_USER_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx           (rx),
        .accepted_type(accepted_type_reg),
        .q_full       (q_full),
        .push         (q_push),
        .push_job     (q_push_job),
        .store_wr     (store_wr),
        .bank_rel     (bank_rel)
    );

    // Queue: decouple byte parsing from the result runs at frame end.
    erfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_push_job),
        .pop       (q_pop),
        .head_valid(q_head_valid),
        .head      (q_head),
        .full      (q_full)
    );

    // Back: read out user bytes, then the summary or the error status.
    erfp_back #(
        .MAX_USER_BYTES(MAX_USER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(q_head_valid),
        .head      (q_head),
        .pop       (q_pop),
        .store_wr  (store_wr),
        .bank_rel  (bank_rel),
        .res       (res)
    );

endmodule
